// File: design/hcl_pkg.sv
// ----------------------------------------------------------------------------
// hcl_pkg - shared types and constants for the hex command line parser
// Line store geometry, queue depth, status codes and the beat and result
// structs passed between the front, the queue and the back.
// ----------------------------------------------------------------------------
package hcl_pkg;

  // Line store geometry
  localparam int LINE_DEPTH    = 36;
  localparam int MAX_ARGUMENTS = 3;
  localparam int ADDR_W        = $clog2(LINE_DEPTH);
  localparam int CNT_W         = $clog2(LINE_DEPTH + 1);
  localparam int GROUP_CHARS   = 8;

  // Reported argument slots and pair walk sizing
  localparam int NUM_ARG_OUT   = 3;
  localparam int SLOT_W        = $clog2(NUM_ARG_OUT);
  localparam int PAIRS_MAX     = 1 + 4 * MAX_ARGUMENTS;
  localparam int PAIR_W        = $clog2(PAIRS_MAX + 1);
  localparam int BEAT_W        = $clog2(PAIRS_MAX);

  // Queue between front and back
  localparam int QDEPTH        = 4;
  localparam int Q_AW          = $clog2(QDEPTH);
  localparam int Q_CW          = $clog2(QDEPTH + 1);

  // Character codes and reset values
  localparam logic [7:0] CHAR_CR          = 8'h0D;
  localparam logic [7:0] CHAR_LF          = 8'h0A;
  localparam logic [7:0] DIGIT_OFFSET_RST = 8'd48;
  localparam logic [2:0] ARGC_SAT         = 3'd7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_CMD   = 2'd1,
    ST_SYNTAX   = 2'd2,
    ST_TOO_MANY = 2'd3
  } hcl_status_e;

  typedef enum logic {
    FS_IDLE,
    FS_WALK
  } hcl_front_state_e;

  typedef logic [NUM_ARG_OUT-1:0][31:0] hcl_args_t;

  // One decoded byte of a line, tagged with the line's classification
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    hcl_status_e status;
    logic [2:0]  arg_count;
  } hcl_beat_t;

  typedef struct packed {
    logic [7:0]  command_code;
    logic [2:0]  arg_count;
    hcl_args_t   args;
    hcl_status_e status;
  } hcl_result_t;

endpackage

// File: design/hex_command_line_parser.sv
// ----------------------------------------------------------------------------
// hex_command_line_parser - serial command line parser
// Line store, CR LF detection and hex decoding of a command and arguments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / rx_byte_i) takes one received
//   character per beat. Bytes that do not end a line are taken one per
//   cycle. An LF after CR closes the line and yields one result beat on
//   the output channel (out_valid_o / out_ready_i); other bytes yield none.
//   At a line end the front walks the stored characters in pairs, one pair
//   per cycle while the queue has room, through the two read ports of the
//   line store: 1 + 4 * groups pairs for a well formed line (at most 13),
//   one pair otherwise. Input is held off until the last pair has entered
//   the queue. A four-entry beat queue and the result register decouple
//   the walk from a stalled receiver; the walk pauses when the queue fills
//   and the result holds until taken. cfg_we_i writes digit_offset from
//   cfg_wdata_i, only while idle; the user must keep to that, the block
//   does not enforce it. Reset empties the line store (no clearing pass)
//   and sets digit_offset to the ASCII code of '0'.
// ----------------------------------------------------------------------------
module hex_command_line_parser import hcl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         command_code_o,
  output logic [2:0]         arg_count_o,
  output logic signed [31:0] arg_first_o,
  output logic signed [31:0] arg_second_o,
  output logic signed [31:0] arg_third_o,
  output logic [1:0]         parse_status_o
);

  logic [7:0]  offset_q;
  hcl_beat_t   f_beat, b_beat;
  logic        f_valid, f_ready, b_valid, b_ready;
  hcl_result_t result;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= DIGIT_OFFSET_RST;
    end else if (cfg_we_i) begin
      offset_q <= cfg_wdata_i;
    end
  end

  hcl_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .digit_offset_i (offset_q),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .rx_byte_i      (rx_byte_i),
    .beat_o         (f_beat),
    .beat_valid_o   (f_valid),
    .beat_ready_i   (f_ready)
  );

  hcl_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_beat_i  (f_beat),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_beat_o   (b_beat),
    .pop_valid_o  (b_valid),
    .pop_ready_i  (b_ready)
  );

  hcl_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .beat_i       (b_beat),
    .beat_valid_i (b_valid),
    .beat_ready_o (b_ready),
    .result_o     (result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

  // Drive result fields
  assign command_code_o = result.command_code;
  assign arg_count_o    = result.arg_count;
  assign arg_first_o    = signed'(result.args[0]);
  assign arg_second_o   = signed'(result.args[1]);
  assign arg_third_o    = signed'(result.args[2]);
  assign parse_status_o = result.status;

  a_nocmd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (parse_status_o == ST_NO_CMD)) |->
      ((command_code_o == 8'h00) && (arg_count_o == 3'd0) && (arg_first_o == 0)))
    else $error("no-command result carries nonzero fields");

  a_syntax_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (parse_status_o == ST_SYNTAX)) |->
      ((arg_count_o == 3'd0) && (arg_first_o == 0) && (arg_second_o == 0)))
    else $error("syntax-error result carries arguments");

endmodule

// File: design/hcl_front.sv
// ----------------------------------------------------------------------------
// hcl_front - byte intake, line store and line classification
// Appends received bytes to a circular line store, detects CR LF, classifies
// the line and walks its stored characters in pairs, emitting decoded bytes.
// ----------------------------------------------------------------------------
module hcl_front import hcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  digit_offset_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  output hcl_beat_t   beat_o,
  output logic        beat_valid_o,
  input  logic        beat_ready_i
);

  function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
    logic [ADDR_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (ADDR_W + 1)'(LINE_DEPTH)) begin
      sum = sum - (ADDR_W + 1)'(LINE_DEPTH);
    end
    return sum[ADDR_W-1:0];
  endfunction

  hcl_front_state_e  state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] head_q, head_d;
  logic [7:0]        prev_q, prev_d;
  logic [ADDR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PAIR_W-1:0] pairs_q, pairs_d;
  logic              rd_valid_q, rd_valid_d;
  hcl_status_e       status_q, status_d;
  logic [2:0]        argc_q, argc_d;
  logic              zero_q, zero_d;

  logic [7:0]        mem [LINE_DEPTH];
  logic [7:0]        rd0_q, rd1_q;

  logic              in_acc, line_end, wr_en, rd_en, push;
  logic [ADDR_W-1:0] wr_addr;
  logic [CNT_W-1:0]  len, len_m2, groups;
  hcl_status_e       cls_status;
  logic [2:0]        cls_argc;
  logic [PAIR_W-1:0] cls_pairs;
  logic              cls_zero;
  logic [7:0]        hi_val, lo_val;

  assign in_ready_o = (state_q == FS_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign line_end   = (cnt_q != '0) && (prev_q == CHAR_CR) && (rx_byte_i == CHAR_LF);
  assign wr_addr    = wrap_add(head_q, cnt_q[ADDR_W-1:0]);
  assign wr_en      = in_acc && !line_end;
  assign push       = rd_valid_q && beat_ready_i;

  // Classify the line that ends with the current LF
  always_comb begin
    len    = cnt_q - CNT_W'(1);
    len_m2 = len - CNT_W'(2);
    groups = CNT_W'(len_m2 / GROUP_CHARS);
    if (len < CNT_W'(2)) begin
      cls_status = ST_NO_CMD;
      cls_argc   = '0;
      cls_pairs  = PAIR_W'(1);
      cls_zero   = 1'b1;
    end else if ((len_m2 % GROUP_CHARS) != 0) begin
      cls_status = ST_SYNTAX;
      cls_argc   = '0;
      cls_pairs  = PAIR_W'(1);
      cls_zero   = 1'b0;
    end else if (groups > CNT_W'(MAX_ARGUMENTS)) begin
      cls_status = ST_TOO_MANY;
      cls_argc   = (groups > CNT_W'(ARGC_SAT)) ? ARGC_SAT : groups[2:0];
      cls_pairs  = PAIR_W'(1);
      cls_zero   = 1'b0;
    end else begin
      cls_status = ST_OK;
      cls_argc   = groups[2:0];
      cls_pairs  = PAIR_W'(1) + (PAIR_W'(groups) << 2);
      cls_zero   = 1'b0;
    end
  end

  // Next state: take bytes while idle, walk stored pairs after a line end
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    head_d     = head_q;
    prev_d     = prev_q;
    rd_ptr_d   = rd_ptr_q;
    pairs_d    = pairs_q;
    rd_valid_d = rd_valid_q;
    status_d   = status_q;
    argc_d     = argc_q;
    zero_d     = zero_q;
    rd_en      = 1'b0;
    case (state_q)
      FS_IDLE: begin
        if (in_acc) begin
          if (line_end) begin
            status_d = cls_status;
            argc_d   = cls_argc;
            pairs_d  = cls_pairs;
            zero_d   = cls_zero;
            rd_ptr_d = head_q;
            cnt_d    = '0;
            head_d   = '0;
            state_d  = FS_WALK;
          end else begin
            prev_d = rx_byte_i;
            // drop the oldest byte when the store fills up
            if (cnt_q == CNT_W'(LINE_DEPTH - 1)) begin
              head_d = wrap_add(head_q, ADDR_W'(1));
            end else begin
              cnt_d = cnt_q + CNT_W'(1);
            end
          end
        end
      end
      FS_WALK: begin
        rd_en = (pairs_q != '0) && (!rd_valid_q || push);
        if (rd_en) begin
          rd_ptr_d   = wrap_add(rd_ptr_q, ADDR_W'(2));
          pairs_d    = pairs_q - PAIR_W'(1);
          rd_valid_d = 1'b1;
        end else if (push) begin
          rd_valid_d = 1'b0;
        end
        if (push && (pairs_q == '0)) begin
          state_d = FS_IDLE;
        end
      end
      default: begin
        state_d = FS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= FS_IDLE;
      cnt_q      <= '0;
      head_q     <= '0;
      prev_q     <= '0;
      rd_ptr_q   <= '0;
      pairs_q    <= '0;
      rd_valid_q <= 1'b0;
      status_q   <= ST_OK;
      argc_q     <= '0;
      zero_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      head_q     <= head_d;
      prev_q     <= prev_d;
      rd_ptr_q   <= rd_ptr_d;
      pairs_q    <= pairs_d;
      rd_valid_q <= rd_valid_d;
      status_q   <= status_d;
      argc_q     <= argc_d;
      zero_q     <= zero_d;
    end
  end

  // Line store: one write port, two registered read ports for a pair
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= rx_byte_i;
    end
    if (rd_en) begin
      rd0_q <= mem[rd_ptr_q];
      rd1_q <= mem[wrap_add(rd_ptr_q, ADDR_W'(1))];
    end
  end

  // Decode the held pair into one byte
  assign hi_val = rd0_q - digit_offset_i;
  assign lo_val = rd1_q - digit_offset_i;

  assign beat_valid_o     = rd_valid_q;
  assign beat_o.data      = zero_q ? 8'h00 : ({hi_val[3:0], 4'h0} + lo_val);
  assign beat_o.last      = (pairs_q == '0);
  assign beat_o.status    = status_q;
  assign beat_o.arg_count = argc_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q < CNT_W'(LINE_DEPTH))
    else $error("line store fill count reached depth");

  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == FS_IDLE) |-> (!rd_valid_q && (pairs_q == '0)))
    else $error("pair walk left work pending on return to idle");

  a_walk_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && (pairs_q == '0)) |=> (state_q == FS_IDLE))
    else $error("last beat pushed without ending the walk");

endmodule

// File: design/hcl_fifo.sv
// ----------------------------------------------------------------------------
// hcl_fifo - short beat queue between front and back
// Flop based queue of decoded beats so each side can stall on its own.
// ----------------------------------------------------------------------------
module hcl_fifo import hcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  hcl_beat_t push_beat_i,
  input  logic      push_valid_i,
  output logic      push_ready_o,
  output hcl_beat_t pop_beat_o,
  output logic      pop_valid_o,
  input  logic      pop_ready_i
);

  hcl_beat_t       slots_q [QDEPTH];
  logic [Q_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_CW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != Q_CW'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_beat_o   = slots_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == Q_AW'(QDEPTH - 1)) ? '0 : wr_ptr_q + Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == Q_AW'(QDEPTH - 1)) ? '0 : rd_ptr_q + Q_AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + Q_CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - Q_CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Hold beat payloads
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_beat_i;
    end
  end

endmodule

// File: design/hcl_back.sv
// ----------------------------------------------------------------------------
// hcl_back - result assembly
// Collects decoded beats into the command byte and argument words and
// presents one result per line through an output register.
// ----------------------------------------------------------------------------
module hcl_back import hcl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  hcl_beat_t   beat_i,
  input  logic        beat_valid_i,
  output logic        beat_ready_o,
  output hcl_result_t result_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  logic [BEAT_W-1:0] idx_q, idx_d;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        cmd_q;
  hcl_args_t         arg_q;
  hcl_result_t       res_q;

  logic              acc;
  logic [7:0]        cmd_w;
  hcl_args_t         arg_w;
  logic [BEAT_W-1:0] slot;

  assign beat_ready_o = !out_valid_q || out_ready_i;
  assign acc          = beat_valid_i && beat_ready_o;

  // Command byte from the first beat; later beats shift into an argument word
  always_comb begin
    cmd_w = (idx_q == '0) ? beat_i.data : cmd_q;
    arg_w = (idx_q == '0) ? '0 : arg_q;
    slot  = (idx_q - BEAT_W'(1)) >> 2;
    if ((idx_q != '0) && (slot < BEAT_W'(NUM_ARG_OUT))) begin
      arg_w[slot[SLOT_W-1:0]] = {arg_w[slot[SLOT_W-1:0]][23:0], beat_i.data};
    end
  end

  // Beat counter and output valid
  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (acc) begin
      if (beat_i.last) begin
        idx_d       = '0;
        out_valid_d = 1'b1;
      end else begin
        idx_d = idx_q + BEAT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Hold working words and load the result on the last beat
  always_ff @(posedge clk_i) begin
    if (acc) begin
      cmd_q <= cmd_w;
      arg_q <= arg_w;
      if (beat_i.last) begin
        res_q.command_code <= cmd_w;
        res_q.arg_count    <= beat_i.arg_count;
        res_q.args         <= arg_w;
        res_q.status       <= beat_i.status;
      end
    end
  end

  assign result_o    = res_q;
  assign out_valid_o = out_valid_q;

endmodule

// File: dv/tb_hex_command_line_parser.sv
// ----------------------------------------------------------------------------
// tb_hex_command_line_parser - self-checking bench for the command parser
// Streams received characters into the parser through a randomly paced
// driver, predicts each completed line's decode in a line model kept in the
// bench, and checks every result beat against the oldest prediction. The
// digit offset is rewritten between phases while the parser is idle.
// ----------------------------------------------------------------------------
module tb_hex_command_line_parser;
  import hcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE      = 40;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0]  cmd;
    logic [2:0]  argc;
    logic [31:0] arg0;
    logic [31:0] arg1;
    logic [31:0] arg2;
    hcl_status_e status;
  } line_result_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we      = 1'b0;
  logic [7:0]  cfg_wdata   = 8'd0;
  logic        in_valid    = 1'b0;
  logic [7:0]  rx_byte     = 8'd0;
  logic        out_ready   = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [7:0]  command_code;
  logic [2:0]  arg_count;
  logic signed [31:0] arg_first;
  logic signed [31:0] arg_second;
  logic signed [31:0] arg_third;
  logic [1:0]  parse_status;

  // Bench copy of the line store and the offset register
  logic [7:0]  line_buf [LINE_DEPTH];
  int unsigned line_len   = 0;
  logic [7:0]  digit_off  = DIGIT_OFFSET_RST;

  logic [7:0]   char_q [$];
  line_result_t decode_q [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          press_on      = 1'b0;
  bit          hold_used     = 1'b0;
  int unsigned hold_left     = 0;
  int unsigned fail_cnt      = 0;
  int unsigned cycle_cnt     = 0;
  int unsigned chars_sent    = 0;
  int unsigned lines_seen    = 0;
  int unsigned status_hits [4];

  hex_command_line_parser u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .command_code_o (command_code),
    .arg_count_o    (arg_count),
    .arg_first_o    (arg_first),
    .arg_second_o   (arg_second),
    .arg_third_o    (arg_third),
    .parse_status_o (parse_status)
  );

  always #5 clk_i = ~clk_i;

  // Nibble pair at a store position, decoded with the current offset
  function automatic logic [7:0] pair_value(int unsigned pos);
    logic [7:0] hi;
    logic [7:0] lo;
    hi = line_buf[pos % LINE_DEPTH] - digit_off;
    lo = line_buf[(pos + 1) % LINE_DEPTH] - digit_off;
    return {hi[3:0], 4'h0} + lo;
  endfunction

  function automatic logic [31:0] word_value(int unsigned pos);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      w = {w[23:0], pair_value(pos + 2 * k)};
    end
    return w;
  endfunction

  // Store one character; return 1 with the decoded line when CR LF closes it
  function automatic bit accept_char(input logic [7:0] c, output line_result_t res);
    int unsigned n;
    int unsigned len;
    int unsigned groups;
    logic [31:0] words [3];
    res = '0;
    if (line_len >= LINE_DEPTH) line_len = LINE_DEPTH - 1;
    line_buf[line_len] = c;
    n = line_len + 1;
    if (n >= 2 && line_buf[n-2] == CHAR_CR && line_buf[n-1] == CHAR_LF) begin
      len = n - 2;
      line_len = 0;
      if (len < 2) begin
        res.status = ST_NO_CMD;
        return 1'b1;
      end
      res.cmd = pair_value(0);
      if ((len - 2) % GROUP_CHARS != 0) begin
        res.status = ST_SYNTAX;
        return 1'b1;
      end
      groups = (len - 2) / GROUP_CHARS;
      if (groups > MAX_ARGUMENTS) begin
        res.argc   = (groups > 7) ? 3'd7 : 3'(groups);
        res.status = ST_TOO_MANY;
        return 1'b1;
      end
      res.argc = 3'(groups);
      for (int i = 0; i < 3; i++) begin
        words[i] = (i < groups) ? word_value(2 + i * GROUP_CHARS) : 32'd0;
      end
      res.arg0   = words[0];
      res.arg1   = words[1];
      res.arg2   = words[2];
      res.status = ST_OK;
      return 1'b1;
    end
    // Drop the oldest character when the store fills without a line end
    if (n == LINE_DEPTH) begin
      for (int i = 0; i < LINE_DEPTH - 1; i++) line_buf[i] = line_buf[i+1];
      n = n - 1;
    end
    line_len = n;
    return 1'b0;
  endfunction

  // Driver: predict on each accepted beat, then offer the next character
  always @(posedge clk_i) begin : drive_chars
    line_result_t res;
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        chars_sent++;
        if (accept_char(rx_byte, res)) decode_q.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (char_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte  <= char_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
    end
  endtask

  // Monitor: compare each result beat, pace ready, one long hold-off
  always @(posedge clk_i) begin : watch_results
    line_result_t exp_r;
    bit start_hold;
    start_hold = 1'b0;
    if (rst_ni) begin
      if (out_valid && out_ready) begin
        lines_seen++;
        status_hits[parse_status]++;
        if (decode_q.size() == 0) begin
          fail_cnt++;
          $display("%0t: result beat with no line pending, status %0d",
                   $time, parse_status);
        end else begin
          exp_r = decode_q.pop_front();
          check_field("command_code", 32'(exp_r.cmd), 32'(command_code));
          check_field("arg_count", 32'(exp_r.argc), 32'(arg_count));
          check_field("arg_first", exp_r.arg0, arg_first);
          check_field("arg_second", exp_r.arg1, arg_second);
          check_field("arg_third", exp_r.arg2, arg_third);
          check_field("parse_status", 32'(exp_r.status), 32'(parse_status));
        end
        start_hold = press_on && !hold_used;
      end
      if (start_hold) begin
        hold_used <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("[hex_command_line_parser] ERROR");
      $finish;
    end
  end

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) char_q.push_back(s[i]);
  endtask

  // Character for a random line body: offset digits, ASCII hex or any code
  function automatic logic [7:0] body_char(logic [7:0] off);
    int unsigned r;
    string hex_set;
    hex_set = "0123456789ABCDEF";
    r = $urandom_range(3);
    if (r < 2) return off + 8'($urandom_range(15));
    if (r == 2) return hex_set[$urandom_range(15)];
    return 8'($urandom_range(255));
  endfunction

  // Queue random lines until n characters are pending
  task automatic add_lines(int unsigned n, logic [7:0] off);
    int unsigned base;
    int unsigned r;
    int unsigned groups;
    int unsigned mode;
    int unsigned len;
    logic [3:0]  nib;
    base = char_q.size();
    while (char_q.size() - base < n) begin
      r = $urandom_range(99);
      if (r < 70) begin
        // Well-formed line: command pair and whole argument groups
        groups = ($urandom_range(9) == 0) ? 4 : $urandom_range(3);
        char_q.push_back(off + 8'($urandom_range(15)));
        char_q.push_back(off + 8'($urandom_range(15)));
        for (int g = 0; g < groups; g++) begin
          mode = $urandom_range(7);
          for (int j = 0; j < GROUP_CHARS; j++) begin
            case (mode)
              0:       nib = 4'h0;
              1:       nib = 4'hF;
              2:       nib = (j == 0) ? 4'h8 : 4'h0;
              3:       nib = (j == 0) ? 4'h7 : 4'hF;
              default: nib = 4'($urandom_range(15));
            endcase
            char_q.push_back(off + 8'(nib));
          end
        end
        char_q.push_back(CHAR_CR);
        char_q.push_back(CHAR_LF);
      end else if (r < 80 || r < 88) begin
        // Random length, or an overlong line that overflows the store
        len = (r < 80) ? $urandom_range(33) : $urandom_range(36, 45);
        for (int i = 0; i < len; i++) char_q.push_back(body_char(off));
        char_q.push_back(CHAR_CR);
        char_q.push_back(CHAR_LF);
      end else begin
        // Noise: stray CR, stray LF, raw codes
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(3))
            0:       char_q.push_back(CHAR_CR);
            1:       char_q.push_back(CHAR_LF);
            default: char_q.push_back(8'($urandom_range(255)));
          endcase
        end
      end
    end
  endtask

  task automatic wait_idle();
    while (char_q.size() != 0 || in_valid || decode_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_offset(logic [7:0] v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    digit_off = v;
  endtask

  initial begin
    for (int i = 0; i < 4; i++) status_hits[i] = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed lines at the reset offset: empty, CR only, largest command,
    // stray LF with a bad length, one argument of all ones
    send_idle_pct = 6;
    recv_idle_pct = 70;
    push_text("\r\n");
    push_text("\r\r\n");
    push_text("??\r\n");
    push_text("1\n3\r\n");
    push_text("01????????\r\n");
    wait_idle();

    // Offset extremes with a slow receiver
    write_offset(8'h00);
    add_lines(250, 8'h00);
    wait_idle();
    write_offset(8'hFF);
    add_lines(250, 8'hFF);
    wait_idle();

    // Slow sender, fast receiver
    send_idle_pct = 70;
    recv_idle_pct = 6;
    write_offset(8'($urandom_range(255)));
    add_lines(300, digit_off);
    wait_idle();
    write_offset(DIGIT_OFFSET_RST);
    add_lines(300, digit_off);
    wait_idle();

    // Full rate both sides, with one long receiver stall
    send_idle_pct = 0;
    recv_idle_pct = 0;
    press_on      = 1'b1;
    write_offset(8'($urandom_range(255)));
    add_lines(350, digit_off);
    wait_idle();

    if (decode_q.size() != 0) begin
      fail_cnt++;
      $display("%0t: %0d line results never arrived", $time, decode_q.size());
    end
    $display("Sent %0d characters, checked %0d lines in %0d cycles",
             chars_sent, lines_seen, cycle_cnt);
    $display("Status counts: ok %0d, no command %0d, syntax %0d, too many %0d",
             status_hits[ST_OK], status_hits[ST_NO_CMD], status_hits[ST_SYNTAX],
             status_hits[ST_TOO_MANY]);
    if (fail_cnt == 0) begin
      $display("[hex_command_line_parser] OK");
    end else begin
      $display("[hex_command_line_parser] ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/hcl_pkg.sv
design/hcl_front.sv
design/hcl_fifo.sv
design/hcl_back.sv
design/hex_command_line_parser.sv
dv/tb_hex_command_line_parser.sv
